// ===== design/pal_pkg.sv =====
// Shared codes and control types for the positional array list.
package pal_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 64;
    localparam int STAT_W  = 2;
    localparam int CNTO_W  = 8;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_TAIL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_POS  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic load;
        logic setup;
        logic move;
        logic finish;
        logic commit;
    } pal_cmd_t;

    typedef struct packed {
        logic go_move;
        logic done;
    } pal_stat_t;

endpackage

// ===== design/positional_array_list.sv =====
// Positional array list: bounded ordered list with insert/remove at head, tail or position.
// Each accepted word is decoded; unless it is rejected or a no-op, the count - position entries
// from its position on are then read and shifted, and the reply word is registered last.
// One word at a time: the next word is taken only after the result is registered,
// and is delayed further while a previous result waits on m_tready.
// Reset clears the count and handshake state; entry memory is not cleared.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY    = 128,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // command[2:0], position[10:3], entry_value[74:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status[1:0], removed_value[65:2], count_after[73:66]
);
    pal_cmd_t          dp_cmd;
    pal_stat_t         dp_stat;
    logic [STAT_W-1:0] out_status;
    logic [VAL_W-1:0]  out_removed_value;
    logic [CNTO_W-1:0] out_count_after;

    pal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    pal_dpath #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .dp_cmd            (dp_cmd),
        .dp_stat           (dp_stat),
        .in_command        (s_tdata[2:0]),
        .in_position       (s_tdata[10:3]),
        .in_entry_value    (s_tdata[74:11]),
        .out_status        (out_status),
        .out_removed_value (out_removed_value),
        .out_count_after   (out_count_after)
    );

    assign m_tdata = {6'd0, out_count_after, out_removed_value, out_status};
endmodule

// ===== design/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/pal_ctrl.sv =====
// Sequencer for the positional array list: accept, decode, shift, deliver.
module pal_ctrl
    import pal_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  pal_stat_t dp_stat,
    output pal_cmd_t  dp_cmd
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_MOVE   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                dp_cmd.setup = 1'b1;
                state_next   = dp_stat.go_move ? S_MOVE : S_RESULT;
            end
            S_MOVE: begin
                dp_cmd.move = 1'b1;
                if (dp_stat.done) begin
                    dp_cmd.finish = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the output register can take the word
                if (out_free) begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (dp_cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    a_accept_to_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted word did not enter decode");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("result overwrote a pending output word");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({dp_cmd.load, dp_cmd.setup, dp_cmd.move, dp_cmd.commit}))
        else $error("conflicting datapath commands");
endmodule

// ===== design/pal_dpath.sv =====
// Datapath: request registers, count, entry memory with shift engine, result registers.
module pal_dpath
    import pal_pkg::*;
#(
    parameter int CAPACITY    = 128,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pal_cmd_t          dp_cmd,
    output pal_stat_t         dp_stat,
    input  logic [CMD_W-1:0]  in_command,
    input  logic [POS_W-1:0]  in_position,
    input  logic [VAL_W-1:0]  in_entry_value,
    output logic [STAT_W-1:0] out_status,
    output logic [VAL_W-1:0]  out_removed_value,
    output logic [CNTO_W-1:0] out_count_after
);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]          count_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [ENTRY_WIDTH-1:0] val_reg;
    logic [AW-1:0]          ea_reg;
    logic                   dir_ins_reg;
    logic                   ok_reg;
    logic [STAT_W-1:0]      status_reg;
    logic [AW-1:0]          rd_ptr_reg;
    logic [AW-1:0]          wr_ptr_reg;
    logic                   wr_pend_reg;
    logic                   first_reg;
    logic [CW-1:0]          left_reg;
    logic [ENTRY_WIDTH-1:0] removed_reg;
    logic [STAT_W-1:0]      out_status_reg;
    logic [ENTRY_WIDTH-1:0] out_removed_reg;
    logic [CNTO_W-1:0]      out_count_reg;

    // decode
    logic              is_ins, is_rem, go_move;
    logic [CMPW-1:0]   pos_ext, count_ext, eff, left_ext, new_count_ext;
    logic [STAT_W-1:0] dec_status;
    logic [CW-1:0]     count_m1, new_count;

    always_comb begin
        pos_ext              = '0;
        pos_ext[POS_W-1:0]   = pos_reg;
        count_ext            = '0;
        count_ext[CW-1:0]    = count_reg;
        is_ins = (cmd_reg == CMD_INS_HEAD) || (cmd_reg == CMD_INS_TAIL)
              || (cmd_reg == CMD_INS_POS);
        is_rem = (cmd_reg == CMD_REM_HEAD) || (cmd_reg == CMD_REM_TAIL)
              || (cmd_reg == CMD_REM_POS);
        case (cmd_reg)
            CMD_INS_HEAD: eff = '0;
            CMD_INS_TAIL: eff = count_ext;
            CMD_REM_HEAD: eff = '0;
            CMD_REM_TAIL: eff = count_ext - CMPW'(1);
            default:      eff = pos_ext;
        endcase
        dec_status = ST_OK;
        if (is_ins) begin
            if (count_reg == CW'(CAPACITY)) begin
                dec_status = ST_FULL;
            end else if (eff > count_ext) begin
                dec_status = ST_RANGE;
            end
        end else if (is_rem) begin
            if (count_reg == '0) begin
                dec_status = ST_EMPTY;
            end else if (eff >= count_ext) begin
                dec_status = ST_RANGE;
            end
        end
        go_move  = (is_ins || is_rem) && (dec_status == ST_OK);
        // entries touched: insert shifts count-eff up, remove reads eff..count-1
        left_ext = count_ext - eff;
        count_m1 = count_reg - CW'(1);
    end

    assign dp_stat.go_move = go_move;
    assign dp_stat.done    = (left_reg == '0) && !wr_pend_reg;

    // entry memory
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;
    logic                   val_write;

    assign val_write = dp_cmd.finish && dir_ins_reg;

    always_comb begin
        ram_re    = dp_cmd.move && (left_reg != '0);
        ram_we    = (wr_pend_reg && !first_reg) || val_write;
        ram_waddr = val_write ? ea_reg : wr_ptr_reg;
        ram_wdata = val_write ? val_reg : ram_rdata;
    end

    pal_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        new_count = count_reg;
        if (ok_reg) begin
            new_count = dir_ins_reg ? count_reg + CW'(1) : count_m1;
        end
        new_count_ext           = '0;
        new_count_ext[CW-1:0]   = new_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end else begin
            if (dp_cmd.load) begin
                cmd_reg <= in_command;
                pos_reg <= in_position;
                val_reg <= in_entry_value[ENTRY_WIDTH-1:0];
            end
            if (dp_cmd.setup) begin
                status_reg  <= dec_status;
                ok_reg      <= go_move;
                ea_reg      <= eff[AW-1:0];
                dir_ins_reg <= is_ins;
                first_reg   <= is_rem;
                removed_reg <= '0;
                left_reg    <= go_move ? left_ext[CW-1:0] : '0;
                rd_ptr_reg  <= is_ins ? count_m1[AW-1:0] : eff[AW-1:0];
            end
            wr_pend_reg <= dp_cmd.move && (left_reg != '0);
            if (dp_cmd.move) begin
                if (left_reg != '0) begin
                    rd_ptr_reg <= dir_ins_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                    wr_ptr_reg <= dir_ins_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
                    left_reg   <= left_reg - CW'(1);
                end
                // first word read on a removal is the removed entry, not a move
                if (wr_pend_reg && first_reg) begin
                    removed_reg <= ram_rdata;
                    first_reg   <= 1'b0;
                end
            end
            if (dp_cmd.commit) begin
                count_reg       <= new_count;
                out_status_reg  <= status_reg;
                out_removed_reg <= removed_reg;
                out_count_reg   <= new_count_ext[CNTO_W-1:0];
            end
        end
    end

    always_comb begin
        out_removed_value                  = '0;
        out_removed_value[ENTRY_WIDTH-1:0] = out_removed_reg;
    end
    assign out_status      = out_status_reg;
    assign out_count_after = out_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("count above capacity");

    a_finish_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.finish |-> !wr_pend_reg)
        else $error("final write collides with a pending shift write");
endmodule

// ===== dv/list_op_checker.sv =====
`timescale 1ns / 100ps
// Checker for the positional array list: mirrors the list, predicts each reply word and compares.
module list_op_checker
    import pal_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,   // command[2:0], position[10:3], entry_value[74:11]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,   // status[1:0], removed_value[65:2], count_after[73:66]
    output int          fail_count,
    output int          awaited
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  removed_value;
        logic [CNTO_W-1:0] count_after;
    } reply_t;

    logic [VAL_W-1:0] shadow_list [CAPACITY];
    int unsigned      shadow_len;
    reply_t           awaited_replies [$];

    // Apply one command to the mirrored list and return the reply it should produce.
    function automatic reply_t apply_list_op(input logic [CMD_W-1:0] op,
                                             input logic [POS_W-1:0] spot,
                                             input logic [VAL_W-1:0] value);
        reply_t      r;
        int unsigned at;
        r  = '0;
        at = spot;
        case (op)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                if (op == CMD_INS_HEAD)
                    at = 0;
                else if (op == CMD_INS_TAIL)
                    at = shadow_len;
                // full is checked ahead of the position
                if (shadow_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (at > shadow_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int unsigned i = shadow_len; i > at; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[at] = value;
                    shadow_len++;
                end
            end
            CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_POS: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (op == CMD_REM_HEAD)
                        at = 0;
                    else if (op == CMD_REM_TAIL)
                        at = shadow_len - 1;
                    if (at >= shadow_len) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.removed_value = shadow_list[at];
                        shadow_len--;
                        for (int unsigned i = at; i < shadow_len; i++)
                            shadow_list[i] = shadow_list[i + 1];
                    end
                end
            end
            default: ;
        endcase
        r.count_after = CNTO_W'(shadow_len);
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            fail_count = 0;
            shadow_len = 0;
            awaited_replies.delete();
        end else begin
            if (s_tvalid && s_tready)
                awaited_replies.push_back(apply_list_op(s_tdata[2:0], s_tdata[10:3],
                                                        s_tdata[74:11]));
            if (m_tvalid && m_tready) begin
                got.status        = m_tdata[1:0];
                got.removed_value = m_tdata[65:2];
                got.count_after   = m_tdata[73:66];
                if (awaited_replies.size() == 0) begin
                    $error("reply word with no command outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.removed_value !== want.removed_value) begin
                        $error("removed_value: expected %h, got %h",
                               want.removed_value, got.removed_value);
                        fail_count++;
                    end
                    if (got.count_after !== want.count_after) begin
                        $error("count_after: expected %0d, got %0d",
                               want.count_after, got.count_after);
                        fail_count++;
                    end
                end
            end
        end
        awaited <= awaited_replies.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the positional array list: clock, reset, command stimulus and verdict.
module testbench;
    import pal_pkg::*;

    localparam int CAPACITY     = 128;
    localparam int RANDOM_WORDS = 1800;
    localparam int CALM_WORDS   = 250;
    localparam int DRAIN_CYCLES = 160;

    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // command[2:0], position[10:3], entry_value[74:11]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;   // status[1:0], removed_value[65:2], count_after[73:66]

    int fail_count;
    int awaited;
    bit calm = 1'b0;        // no idling on either side while set
    int stall_left = 0;
    int list_len;           // entries held, tracked to aim positions
    int peak_len;
    int sent_words;
    int full_hits;
    int empty_hits;
    int range_hits;

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    positional_array_list #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (VAL_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_op_checker #(
        .CAPACITY (CAPACITY)
    ) list_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    // Reply side: holds m_tready low in random stall bursts.
    always @(posedge aclk) begin
        if (calm) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one command word and hold it until taken; maybe idle afterwards.
    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] spot,
                            input logic [VAL_W-1:0] value);
        s_tdata  <= {5'd0, value, spot, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_words++;
        case (op)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS:
                if (list_len >= CAPACITY)
                    full_hits++;
                else if (op == CMD_INS_POS && spot > list_len)
                    range_hits++;
                else
                    list_len++;
            CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_POS:
                if (list_len == 0)
                    empty_hits++;
                else if (op == CMD_REM_POS && spot >= list_len)
                    range_hits++;
                else
                    list_len--;
            default: ;
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Drop valid and hold until every outstanding reply is back.
    task automatic settle_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0)
            @(posedge aclk);
    endtask

    initial begin
        int                 mode;
        int                 seg;
        int                 random_sent;
        int                 roll;
        int                 grow_bias;
        logic [CMD_W-1:0]   op;
        logic [POS_W-1:0]   spot;
        logic [VAL_W-1:0]   value;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        list_len    = 0;
        peak_len    = 0;
        sent_words  = 0;
        full_hits   = 0;
        empty_hits  = 0;
        range_hits  = 0;
        random_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, range edges, append at count, middle moves, no-op codes.
        push_cmd(CMD_REM_HEAD, 8'd0,   '0);
        push_cmd(CMD_REM_TAIL, 8'd0,   '0);
        push_cmd(CMD_REM_POS,  8'd255, '1);
        push_cmd(CMD_INS_POS,  8'd1,   64'h1111_2222_3333_4444);
        push_cmd(CMD_INS_POS,  8'd0,   '1);
        push_cmd(CMD_INS_HEAD, 8'd0,   '0);
        push_cmd(CMD_INS_TAIL, 8'd255, 64'h8000_0000_0000_0001);
        push_cmd(CMD_INS_POS,  8'd3,   64'hA5A5_5A5A_F00F_0FF0);
        push_cmd(CMD_INS_POS,  8'd1,   64'h0123_4567_89AB_CDEF);
        push_cmd(CMD_INS_POS,  8'd6,   64'hDEAD_BEEF_0000_0000);
        push_cmd(CMD_INS_POS,  8'd255, '1);
        push_cmd(CMD_SPARE_LO, 8'd0,   64'hFFFF_0000_FFFF_0000);
        push_cmd(CMD_SPARE_HI, 8'd255, '1);
        push_cmd(CMD_REM_POS,  8'd5,   '1);
        push_cmd(CMD_REM_POS,  8'd255, '0);
        push_cmd(CMD_REM_POS,  8'd2,   '1);
        push_cmd(CMD_REM_TAIL, 8'd128, '1);
        push_cmd(CMD_REM_HEAD, 8'd77,  '1);
        push_cmd(CMD_REM_POS,  8'd0,   '0);
        push_cmd(CMD_REM_POS,  8'd0,   '0);
        push_cmd(CMD_INS_TAIL, 8'd0,   64'h7FFF_FFFF_FFFF_FFFE);
        push_cmd(CMD_REM_TAIL, 8'd0,   '0);
        settle_replies();

        // Random: segments that grow, shrink or churn the list.
        while (random_sent < RANDOM_WORDS) begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(40, 220);
            grow_bias = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            if (random_sent < RANDOM_WORDS - CALM_WORDS)
                calm <= ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg && random_sent < RANDOM_WORDS; k++) begin
                if (random_sent == RANDOM_WORDS - CALM_WORDS)
                    calm <= 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                else if ($urandom_range(0, 99) < grow_bias)
                    op = CMD_W'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
                else
                    op = CMD_W'($urandom_range(CMD_REM_HEAD, CMD_REM_POS));
                roll = $urandom_range(0, 99);
                if (op == CMD_INS_POS)
                    spot = (roll < 80) ? POS_W'($urandom_range(0, list_len)) :
                           (roll < 90) ? POS_W'(list_len + 1) : POS_W'($urandom);
                else if (op == CMD_REM_POS)
                    spot = (roll < 80 && list_len > 0) ?
                           POS_W'($urandom_range(0, list_len - 1)) :
                           (roll < 90) ? POS_W'(list_len) : POS_W'($urandom);
                else
                    spot = POS_W'($urandom);
                value = {$urandom, $urandom};
                push_cmd(op, spot, value);
                random_sent++;
            end
            if (random_sent < RANDOM_WORDS - CALM_WORDS && $urandom_range(0, 3) == 0)
                settle_replies();
        end

        settle_replies();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d command words, list depth peaked at %0d of %0d.",
                 sent_words, peak_len, CAPACITY);
        $display("Rejected: %0d on full list, %0d on empty list, %0d out of range.",
                 full_hits, empty_hits, range_hits);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
